// ===== hdl/llpa_pkg.sv =====
// Shared types and constants of the least-loaded part assigner.
// Holds field widths, register codes, the sequencer states and the part table entry.
// No dependencies.
`default_nettype none

package llpa_pkg;

  localparam int MAX_PARTS_DEF = 8;
  localparam int MAX_NETS_DEF  = 4096;

  localparam int LOAD_W     = 24;
  localparam int CNT_W      = 16;
  localparam int LFSR_W     = 16;
  localparam int WEIGHT_W   = 16;
  localparam int NET_IN_W   = 12;
  localparam int PART_OUT_W = 3;
  localparam int PIU_W      = 4;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [LFSR_W-1:0] LFSR_MASK   = 16'hB400;
  localparam logic [LOAD_W-1:0] LOAD_MAX    = 24'hFF_FFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;
  localparam logic [PIU_W-1:0]  PARTS_RESET = 4'd2;
  localparam logic [LFSR_W-1:0] SEED_RESET  = 16'd1;

  typedef enum logic {
    REG_PARTS_IN_USE = 1'b0,
    REG_RANDOM_SEED  = 1'b1
  } reg_sel_t;

  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_PIN   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_SELECT,
    ST_UPDATE,
    ST_PIN_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [CNT_W-1:0]  cells;
  } part_entry_t;

  // A zero seed would lock the LFSR, so it is replaced by one.
  function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
    return (s == '0) ? LFSR_W'(1) : s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/llpa_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Used for the part table and the net degree store; no dependencies.
`default_nettype none

module llpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/least_loaded_part_assigner.sv =====
// Least-loaded part assigner: top level with sequencer, tie break and APB registers.
// Depends on llpa_pkg and llpa_ram.
//
// Places weighted cells into the least-loaded active part, choosing among equally
// loaded parts with a 16-bit Galois LFSR value modulo the tie count, and counts
// per-net degrees in the part of the current cell. Words are taken one at a time.
// A place word is handled in steps: one read a cycle through the single port of
// the part table to find the minimum and the tied parts, the bit-serial remainder,
// then a walk over the parts to the picked tied part and a read-modify-write of
// the chosen entry. A pin word reads its degree entry on acceptance and writes it
// back incremented; a net beyond the store skips the update.
// After reset the degree store is swept to zero, one entry a cycle, over all
// MAX_NETS * 2**clog2(MAX_PARTS) entries (32768 at the defaults); no word is taken
// during the sweep, while register writes are. A finished result waits in an output
// register, so the next word is taken while it is still stalled.
`default_nettype none

module least_loaded_part_assigner #(
  parameter int MAX_PARTS = llpa_pkg::MAX_PARTS_DEF,
  parameter int MAX_NETS  = llpa_pkg::MAX_NETS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [llpa_pkg::WEIGHT_W-1:0]       cell_weight,
  input  logic [llpa_pkg::NET_IN_W-1:0]       net_number,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kind,
  output logic [llpa_pkg::PART_OUT_W-1:0]     chosen_part,
  output logic [llpa_pkg::CNT_W-1:0]          cell_number,
  output logic [llpa_pkg::LOAD_W-1:0]         new_part_load,
  output logic [llpa_pkg::CNT_W-1:0]          part_cell_total,
  output logic [llpa_pkg::CNT_W-1:0]          new_net_degree,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [llpa_pkg::CFG_AW-1:0]         paddr,
  input  logic [llpa_pkg::CFG_DW-1:0]         pwdata,
  output logic [llpa_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int PART_W  = $clog2(MAX_PARTS);
  localparam int PCNT_W  = $clog2(MAX_PARTS + 1);
  localparam int NET_W   = $clog2(MAX_NETS);
  localparam int DDEPTH  = MAX_NETS * (1 << PART_W);
  localparam int DADDR_W = NET_W + PART_W;
  localparam int MODC_W  = $clog2(llpa_pkg::LFSR_W);
  localparam int LOAD_W  = llpa_pkg::LOAD_W;
  localparam int CNT_W   = llpa_pkg::CNT_W;
  localparam int LFSR_W  = llpa_pkg::LFSR_W;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ llpa_pkg::LFSR_MASK;
    end
    return r;
  endfunction

  llpa_pkg::state_t state, state_next;

  logic [llpa_pkg::PIU_W-1:0] parts_in_use;
  logic [LFSR_W-1:0]          random_seed;
  logic [LFSR_W-1:0]          tie_lfsr;

  logic [PCNT_W-1:0] n_act;
  logic [PCNT_W-1:0] issue_cnt;
  logic [PCNT_W-1:0] ties;
  logic [PCNT_W-1:0] seen;
  logic [PCNT_W-1:0] pick;
  logic              chk_valid;
  logic [PART_W-1:0] chk_idx;
  logic [PART_W-1:0] sel_idx;
  logic [PART_W-1:0] chosen;
  logic [PART_W-1:0] cur_part;
  logic [LOAD_W-1:0] min_load;
  logic [LOAD_W-1:0] cur_load;
  logic [CNT_W-1:0]  cur_cells;
  logic [CNT_W-1:0]  cells_placed;
  logic [CNT_W-1:0]  current_cell;
  logic [MAX_PARTS-1:0] tie_mask;
  logic [LFSR_W-1:0] mod_div;
  logic [MODC_W-1:0] mod_cnt;
  logic [DADDR_W-1:0] clr_cnt;
  logic [DADDR_W-1:0] pin_addr;
  logic              res_kind;
  logic [CNT_W-1:0]  res_degree;
  logic [llpa_pkg::WEIGHT_W-1:0] place_weight;

  // memory ports
  logic                    part_we;
  logic [PART_W-1:0]       part_addr;
  llpa_pkg::part_entry_t   part_wdata;
  llpa_pkg::part_entry_t   part_rd;
  logic                    deg_we;
  logic [DADDR_W-1:0]      deg_addr;
  logic [CNT_W-1:0]        deg_wdata;
  logic [CNT_W-1:0]        deg_rd;

  // combinational helpers
  logic                    accept;
  logic                    cfg_wr;
  llpa_pkg::reg_sel_t      cfg_sel;
  logic [31:0]             piu32;
  logic [31:0]             n32;
  logic [31:0]             net32;
  logic [31:0]             cur_part32;
  logic                    net_in_range;
  logic [DADDR_W-1:0]      in_pin_addr;
  logic [LFSR_W-1:0]       lfsr_adv;
  logic                    scan_last;
  logic [PCNT_W:0]         trial;
  logic [PCNT_W:0]         trial_diff;
  logic [PCNT_W-1:0]       rem_next;
  logic                    sel_hit;
  logic [LOAD_W:0]         ld_sum;
  llpa_pkg::part_entry_t   upd_entry;
  logic [CNT_W-1:0]        deg_new;
  logic                    out_free;

  llpa_ram #(
    .WIDTH ($bits(llpa_pkg::part_entry_t)),
    .DEPTH (MAX_PARTS)
  ) u_part_ram (
    .clk     (clk),
    .wr_en   (part_we),
    .addr    (part_addr),
    .wr_data (part_wdata),
    .rd_data (part_rd)
  );

  llpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DDEPTH)
  ) u_degree_ram (
    .clk     (clk),
    .wr_en   (deg_we),
    .addr    (deg_addr),
    .wr_data (deg_wdata),
    .rd_data (deg_rd)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != llpa_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_sel  = llpa_pkg::reg_sel_t'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      llpa_pkg::REG_PARTS_IN_USE: prdata = llpa_pkg::CFG_DW'(parts_in_use);
      llpa_pkg::REG_RANDOM_SEED:  prdata = llpa_pkg::CFG_DW'(random_seed);
      default:                    prdata = '0;
    endcase
  end

  // Active part count, clamped to the range the part table supports.
  always_comb begin
    piu32 = 32'(parts_in_use);
    if (piu32 < 32'd2) begin
      n32 = 32'd2;
    end else if (piu32 > 32'(MAX_PARTS)) begin
      n32 = 32'(MAX_PARTS);
    end else begin
      n32 = piu32;
    end
  end

  assign net32        = 32'(net_number);
  assign cur_part32   = 32'(cur_part);
  assign net_in_range = net32 < 32'(MAX_NETS);
  assign in_pin_addr  = {net32[NET_W-1:0], cur_part};
  assign lfsr_adv     = lfsr_next(tie_lfsr);
  assign scan_last    = chk_valid && ((32'(chk_idx) + 32'd1) == 32'(n_act));

  // One remainder bit a cycle: shift in the next dividend bit, subtract if it fits.
  assign trial      = {pick, mod_div[LFSR_W-1]};
  assign trial_diff = trial - {1'b0, ties};
  assign rem_next   = (trial >= {1'b0, ties}) ? trial_diff[PCNT_W-1:0] : trial[PCNT_W-1:0];

  assign sel_hit = tie_mask[sel_idx] && (seen == pick);

  assign ld_sum = {1'b0, part_rd.load}
                + {{(LOAD_W + 1 - llpa_pkg::WEIGHT_W){1'b0}}, place_weight};
  assign upd_entry.load  = ld_sum[LOAD_W] ? llpa_pkg::LOAD_MAX : ld_sum[LOAD_W-1:0];
  assign upd_entry.cells = (part_rd.cells == llpa_pkg::CNT_MAX) ? llpa_pkg::CNT_MAX
                                                                : part_rd.cells + 1'b1;
  assign deg_new = (deg_rd == llpa_pkg::CNT_MAX) ? llpa_pkg::CNT_MAX : deg_rd + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      llpa_pkg::ST_CLEAR: begin
        if (clr_cnt == DADDR_W'(DDEPTH - 1)) begin
          state_next = llpa_pkg::ST_IDLE;
        end
      end
      llpa_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == llpa_pkg::CMD_PLACE) begin
            state_next = llpa_pkg::ST_SCAN;
          end else if (net_in_range) begin
            state_next = llpa_pkg::ST_PIN_UPDATE;
          end else begin
            state_next = llpa_pkg::ST_EMIT;
          end
        end
      end
      llpa_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = llpa_pkg::ST_MOD;
        end
      end
      llpa_pkg::ST_MOD: begin
        if (mod_cnt == MODC_W'(LFSR_W - 1)) begin
          state_next = llpa_pkg::ST_SELECT;
        end
      end
      llpa_pkg::ST_SELECT: begin
        if (sel_hit) begin
          state_next = llpa_pkg::ST_UPDATE;
        end
      end
      llpa_pkg::ST_UPDATE:     state_next = llpa_pkg::ST_EMIT;
      llpa_pkg::ST_PIN_UPDATE: state_next = llpa_pkg::ST_EMIT;
      llpa_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = llpa_pkg::ST_IDLE;
        end
      end
      default: state_next = llpa_pkg::ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    part_we    = 1'b0;
    part_addr  = chosen;
    part_wdata = '0;
    deg_we     = 1'b0;
    deg_addr   = pin_addr;
    deg_wdata  = '0;
    unique case (state)
      llpa_pkg::ST_CLEAR: begin
        part_we   = 1'b1;
        part_addr = clr_cnt[PART_W-1:0];
        deg_we    = 1'b1;
        deg_addr  = clr_cnt;
      end
      llpa_pkg::ST_IDLE: begin
        deg_addr = in_pin_addr;
      end
      llpa_pkg::ST_SCAN: begin
        part_addr = issue_cnt[PART_W-1:0];
      end
      llpa_pkg::ST_SELECT: begin
        // Reading every candidate leaves the chosen entry on the read port.
        part_addr = sel_idx;
      end
      llpa_pkg::ST_UPDATE: begin
        part_we    = 1'b1;
        part_wdata = upd_entry;
      end
      llpa_pkg::ST_PIN_UPDATE: begin
        deg_we    = 1'b1;
        deg_wdata = deg_new;
      end
      llpa_pkg::ST_MOD, llpa_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= llpa_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      parts_in_use <= llpa_pkg::PARTS_RESET;
      random_seed  <= llpa_pkg::SEED_RESET;
      tie_lfsr     <= llpa_pkg::seed_value(llpa_pkg::SEED_RESET);
      cur_part     <= '0;
      cur_load     <= '0;
      cur_cells    <= '0;
      cells_placed <= '0;
      current_cell <= '0;
      chk_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        unique case (cfg_sel)
          llpa_pkg::REG_PARTS_IN_USE: parts_in_use <= pwdata[llpa_pkg::PIU_W-1:0];
          llpa_pkg::REG_RANDOM_SEED: begin
            random_seed <= pwdata[LFSR_W-1:0];
            tie_lfsr    <= llpa_pkg::seed_value(pwdata[LFSR_W-1:0]);
          end
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall && (state != llpa_pkg::ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        llpa_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        llpa_pkg::ST_IDLE: begin
          if (accept) begin
            res_kind   <= command;
            res_degree <= '0;
            n_act      <= n32[PCNT_W-1:0];
            issue_cnt  <= '0;
            chk_valid  <= 1'b0;
            pin_addr   <= in_pin_addr;
            if (command == llpa_pkg::CMD_PLACE) begin
              tie_lfsr     <= lfsr_adv;
              mod_div      <= lfsr_adv;
              pick         <= '0;
              mod_cnt      <= '0;
              place_weight <= cell_weight;
            end
          end
        end
        llpa_pkg::ST_SCAN: begin
          if (issue_cnt < n_act) begin
            issue_cnt <= issue_cnt + 1'b1;
            chk_valid <= 1'b1;
            chk_idx   <= issue_cnt[PART_W-1:0];
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid) begin
            // A new minimum restarts the tie set; an equal load joins it.
            if ((chk_idx == '0) || (part_rd.load < min_load)) begin
              min_load <= part_rd.load;
              ties     <= PCNT_W'(1);
              tie_mask <= MAX_PARTS'(1) << chk_idx;
            end else if (part_rd.load == min_load) begin
              ties              <= ties + 1'b1;
              tie_mask[chk_idx] <= 1'b1;
            end
          end
        end
        llpa_pkg::ST_MOD: begin
          pick    <= rem_next;
          mod_div <= mod_div << 1;
          mod_cnt <= mod_cnt + 1'b1;
          sel_idx <= '0;
          seen    <= '0;
        end
        llpa_pkg::ST_SELECT: begin
          if (tie_mask[sel_idx]) begin
            if (seen == pick) begin
              chosen <= sel_idx;
            end else begin
              seen <= seen + 1'b1;
            end
          end
          sel_idx <= sel_idx + 1'b1;
        end
        llpa_pkg::ST_UPDATE: begin
          cur_part     <= chosen;
          cur_load     <= upd_entry.load;
          cur_cells    <= upd_entry.cells;
          current_cell <= cells_placed;
          cells_placed <= cells_placed + 1'b1;
        end
        llpa_pkg::ST_PIN_UPDATE: begin
          res_degree <= deg_new;
        end
        llpa_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            kind            <= res_kind;
            chosen_part     <= cur_part32[llpa_pkg::PART_OUT_W-1:0];
            cell_number     <= current_cell;
            new_part_load   <= cur_load;
            part_cell_total <= cur_cells;
            new_net_degree  <= res_degree;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_lfsr_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == llpa_pkg::CMD_PLACE)) |=> (tie_lfsr == lfsr_next($past(tie_lfsr))))
    else $error("tie-break LFSR did not advance on a placement");

  a_tie_count: assert property (@(posedge clk) disable iff (rst)
    (state == llpa_pkg::ST_MOD) |-> ($countones(tie_mask) == int'(ties)))
    else $error("tie mask and tie count disagree");

  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    (state == llpa_pkg::ST_SELECT) |-> (pick < ties))
    else $error("tie-break pick not below the tie count");

  a_chosen_valid: assert property (@(posedge clk) disable iff (rst)
    (state == llpa_pkg::ST_UPDATE) |-> ((32'(chosen) < 32'(n_act)) && tie_mask[chosen]))
    else $error("chosen part is not an active tied part");

  a_degree_bumped: assert property (@(posedge clk) disable iff (rst)
    (state == llpa_pkg::ST_PIN_UPDATE) |=> (res_degree != '0))
    else $error("net degree is zero after a bump");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for least_loaded_part_assigner.
// A scoreboard class predicts each placement and pin result and checks results in order.
// Depends on llpa_pkg and the block under test; reads and writes no files.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic                            kind;
    logic [llpa_pkg::PART_OUT_W-1:0] part;
    logic [llpa_pkg::CNT_W-1:0]      cell_idx;
    logic [llpa_pkg::LOAD_W-1:0]     load;
    logic [llpa_pkg::CNT_W-1:0]      cells;
    logic [llpa_pkg::CNT_W-1:0]      degree;
  } assignment_t;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  // Tracks loads, cell counts and net degrees of every part, and holds the results owed.
  class placement_scoreboard;
    logic [llpa_pkg::PIU_W-1:0]  parts_reg;
    logic [llpa_pkg::LFSR_W-1:0] tie_state;
    logic [llpa_pkg::LOAD_W-1:0] load [llpa_pkg::MAX_PARTS_DEF];
    logic [llpa_pkg::CNT_W-1:0]  cells [llpa_pkg::MAX_PARTS_DEF];
    logic [llpa_pkg::CNT_W-1:0]  degree [llpa_pkg::MAX_NETS_DEF * llpa_pkg::MAX_PARTS_DEF];
    logic [2:0]                  cur_part;
    logic [llpa_pkg::CNT_W-1:0]  next_cell;
    logic [llpa_pkg::CNT_W-1:0]  cur_cell;
    assignment_t                 owed[$];
    int                          mismatches;

    function new();
      parts_reg = llpa_pkg::PARTS_RESET;
      tie_state = llpa_pkg::SEED_RESET;
      foreach (load[i]) load[i] = '0;
      foreach (cells[i]) cells[i] = '0;
      foreach (degree[i]) degree[i] = '0;
      cur_part = '0;
      next_cell = '0;
      cur_cell = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void write_register(llpa_pkg::reg_sel_t r, logic [31:0] value);
      if (r == llpa_pkg::REG_PARTS_IN_USE) begin
        parts_reg = value[llpa_pkg::PIU_W-1:0];
      end else begin
        tie_state = (value[15:0] == '0) ? 16'd1 : value[15:0];
      end
    endfunction

    function void note_word(llpa_pkg::cmd_t c, logic [llpa_pkg::WEIGHT_W-1:0] weight,
                            logic [llpa_pkg::NET_IN_W-1:0] net);
      int n;
      int ties;
      int pick;
      int seen;
      int k;
      logic [llpa_pkg::LOAD_W-1:0] least;
      logic [llpa_pkg::LOAD_W:0] sum;
      assignment_t e;
      e.degree = '0;
      if (c == llpa_pkg::CMD_PLACE) begin
        n = (parts_reg < 2) ? 2 : ((parts_reg > llpa_pkg::MAX_PARTS_DEF) ?
                                   llpa_pkg::MAX_PARTS_DEF : int'(parts_reg));
        least = load[0];
        for (int j = 1; j < n; j++) if (load[j] < least) least = load[j];
        ties = 0;
        for (int j = 0; j < n; j++) if (load[j] == least) ties++;
        tie_state = (tie_state >> 1) ^ (tie_state[0] ? llpa_pkg::LFSR_MASK : 16'h0);
        pick = tie_state % ties;
        seen = 0;
        // Tied parts are numbered in ascending order; the pick selects one of them.
        for (int j = 0; j < n; j++) begin
          if (load[j] == least) begin
            if (seen == pick) cur_part = 3'(j);
            seen++;
          end
        end
        sum = load[cur_part] + weight;
        load[cur_part] = (sum > llpa_pkg::LOAD_MAX) ? llpa_pkg::LOAD_MAX
                                                    : sum[llpa_pkg::LOAD_W-1:0];
        if (cells[cur_part] != llpa_pkg::CNT_MAX) cells[cur_part] = cells[cur_part] + 1'b1;
        cur_cell = next_cell;
        next_cell = next_cell + 1'b1;
      end else if (net < llpa_pkg::MAX_NETS_DEF) begin
        k = net * llpa_pkg::MAX_PARTS_DEF + cur_part;
        if (degree[k] != llpa_pkg::CNT_MAX) degree[k] = degree[k] + 1'b1;
        e.degree = degree[k];
      end
      e.kind = c;
      e.part = cur_part;
      e.cell_idx = cur_cell;
      e.load = load[cur_part];
      e.cells = cells[cur_part];
      owed.push_back(e);
    endfunction

    function void check_result(assignment_t got);
      assignment_t e;
      if (owed.size() == 0) begin
        flag($sformatf("result kind %0d part %0d with nothing outstanding", got.kind, got.part));
      end else begin
        e = owed.pop_front();
        if (got.kind !== e.kind)
          flag($sformatf("kind expected %0d got %0d", e.kind, got.kind));
        if (got.part !== e.part)
          flag($sformatf("chosen_part expected %0d got %0d", e.part, got.part));
        if (got.cell_idx !== e.cell_idx)
          flag($sformatf("cell_number expected %0d got %0d", e.cell_idx, got.cell_idx));
        if (got.load !== e.load)
          flag($sformatf("new_part_load expected %0d got %0d", e.load, got.load));
        if (got.cells !== e.cells)
          flag($sformatf("part_cell_total expected %0d got %0d", e.cells, got.cells));
        if (got.degree !== e.degree)
          flag($sformatf("new_net_degree expected %0d got %0d", e.degree, got.degree));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic command;
  logic [llpa_pkg::WEIGHT_W-1:0] cell_weight;
  logic [llpa_pkg::NET_IN_W-1:0] net_number;
  logic out_valid;
  logic out_stall;
  logic kind;
  logic [llpa_pkg::PART_OUT_W-1:0] chosen_part;
  logic [llpa_pkg::CNT_W-1:0] cell_number;
  logic [llpa_pkg::LOAD_W-1:0] new_part_load;
  logic [llpa_pkg::CNT_W-1:0] part_cell_total;
  logic [llpa_pkg::CNT_W-1:0] new_net_degree;
  logic psel;
  logic penable;
  logic pwrite;
  logic [llpa_pkg::CFG_AW-1:0] paddr;
  logic [llpa_pkg::CFG_DW-1:0] pwdata;
  logic [llpa_pkg::CFG_DW-1:0] prdata;
  logic pready;

  placement_scoreboard sb;
  int cycles;
  int burst_left;
  int stall_left;
  stall_mode_t stall_mode;

  least_loaded_part_assigner u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .cell_weight(cell_weight),
    .net_number(net_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .chosen_part(chosen_part),
    .cell_number(cell_number),
    .new_part_load(new_part_load),
    .part_cell_total(part_cell_total),
    .new_net_degree(new_net_degree),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall = 1'b0;
      STALL_SPARSE: out_stall = ($urandom_range(0, 2) == 0);
      STALL_HEAVY:  out_stall = ($urandom_range(0, 7) != 0);
      default:      out_stall = ~out_stall;
    endcase
  end

  always @(posedge clk) begin : watch_results
    assignment_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = kind;
      got.part = chosen_part;
      got.cell_idx = cell_number;
      got.load = new_part_load;
      got.cells = part_cell_total;
      got.degree = new_net_degree;
      sb.check_result(got);
    end
  end

  // Called and returns at a falling edge; the word is dropped once it has been taken.
  task automatic send_word(llpa_pkg::cmd_t c, logic [llpa_pkg::WEIGHT_W-1:0] weight,
                           logic [llpa_pkg::NET_IN_W-1:0] net);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    command = c;
    cell_weight = weight;
    net_number = net;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(c, weight, net);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes a register, then reads it back.
  task automatic write_reg(llpa_pkg::reg_sel_t r, logic [15:0] value);
    logic [31:0] word;
    logic [31:0] seen;
    word = $urandom;
    word[15:0] = value;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(r, word);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seen = prdata;
    if (r == llpa_pkg::REG_PARTS_IN_USE &&
        seen[llpa_pkg::PIU_W-1:0] !== word[llpa_pkg::PIU_W-1:0])
      sb.flag($sformatf("parts_in_use read %0d, written %0d",
                        seen[llpa_pkg::PIU_W-1:0], word[llpa_pkg::PIU_W-1:0]));
    if (r == llpa_pkg::REG_RANDOM_SEED && seen[15:0] !== word[15:0])
      sb.flag($sformatf("random_seed read %h, written %h", seen[15:0], word[15:0]));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [llpa_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // A handful of busy nets so that degrees climb well above one.
  function automatic logic [llpa_pkg::NET_IN_W-1:0] pick_net();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 12'hFFF;
      2, 3:    return 12'(12'hA50 + $urandom_range(0, 7));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    int done;
    int pins;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(llpa_pkg::cmd_t'($urandom_range(0, 1)), 16'($urandom), 12'($urandom));
        done++;
      end else begin
        send_word(llpa_pkg::CMD_PLACE, pick_weight(), 12'($urandom));
        done++;
        pins = $urandom_range(0, 5);
        repeat (pins) begin
          send_word(llpa_pkg::CMD_PIN, 16'($urandom), pick_net());
          done++;
        end
      end
    end
  endtask

  task automatic config_phase(logic [llpa_pkg::PIU_W-1:0] parts);
    write_reg(llpa_pkg::REG_PARTS_IN_USE, 16'(parts));
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0:       write_reg(llpa_pkg::REG_RANDOM_SEED, 16'h0000);
        1:       write_reg(llpa_pkg::REG_RANDOM_SEED, 16'hFFFF);
        2:       write_reg(llpa_pkg::REG_RANDOM_SEED, 16'h0001);
        default: write_reg(llpa_pkg::REG_RANDOM_SEED, 16'($urandom_range(1, 65535)));
      endcase
    end
  endtask

  initial begin
    logic [llpa_pkg::PIU_W-1:0] part_choices [12];
    part_choices = '{4'd2, 4'd8, 4'd3, 4'd0, 4'd5, 4'd15, 4'd1, 4'd4, 4'd7, 4'd9, 4'd6, 4'd8};
    rst = 1'b1;
    in_valid = 1'b0;
    command = 1'b0;
    cell_weight = '0;
    net_number = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = STALL_NONE;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pins before any placement land in part 0 against cell 0.
    send_word(llpa_pkg::CMD_PIN, '0, '0);
    send_word(llpa_pkg::CMD_PIN, 16'hFFFF, 12'hFFF);
    send_word(llpa_pkg::CMD_PLACE, '0, '0);
    send_word(llpa_pkg::CMD_PLACE, 16'hFFFF, 12'hFFF);
    send_word(llpa_pkg::CMD_PIN, '0, 12'hFFF);
    send_word(llpa_pkg::CMD_PIN, '0, 12'hFFF);
    send_word(llpa_pkg::CMD_PLACE, 16'd1, '0);
    send_word(llpa_pkg::CMD_PLACE, 16'hFFFF, '0);
    drain();
    write_reg(llpa_pkg::REG_PARTS_IN_USE, 16'd8);
    write_reg(llpa_pkg::REG_RANDOM_SEED, 16'hFFFF);
    repeat (4) send_word(llpa_pkg::CMD_PLACE, '0, '0);
    send_word(llpa_pkg::CMD_PIN, '0, '0);
    drain();
    // A zero seed behaves as one; a part count below two behaves as two.
    write_reg(llpa_pkg::REG_PARTS_IN_USE, 16'd0);
    write_reg(llpa_pkg::REG_RANDOM_SEED, 16'h0000);
    send_word(llpa_pkg::CMD_PLACE, '0, '0);
    send_word(llpa_pkg::CMD_PLACE, 16'h8000, '0);
    send_word(llpa_pkg::CMD_PIN, '0, 12'h800);
    drain();
    // Counts above the maximum behave as the maximum.
    write_reg(llpa_pkg::REG_PARTS_IN_USE, 16'd15);
    write_reg(llpa_pkg::REG_RANDOM_SEED, 16'h0001);
    send_word(llpa_pkg::CMD_PLACE, '0, '0);
    send_word(llpa_pkg::CMD_PLACE, 16'h7FFF, '0);
    send_word(llpa_pkg::CMD_PIN, '0, 12'h001);
    drain();
    write_reg(llpa_pkg::REG_PARTS_IN_USE, 16'd1);
    send_word(llpa_pkg::CMD_PLACE, 16'h00FF, '0);
    send_word(llpa_pkg::CMD_PIN, '0, 12'h001);

    for (int p = 0; p < 12; p++) begin
      drain();
      config_phase(part_choices[p]);
      if (p == 5) begin
        // Heavy cells into two parts drive both loads into saturation.
        write_reg(llpa_pkg::REG_PARTS_IN_USE, 16'd2);
        repeat (560) begin
          send_word(llpa_pkg::CMD_PLACE, 16'hFFFF, 12'($urandom));
          if ($urandom_range(0, 7) == 0) send_word(llpa_pkg::CMD_PIN, 16'($urandom), pick_net());
        end
      end else begin
        random_phase($urandom_range(90, 130));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/llpa_pkg.sv
hdl/llpa_ram.sv
hdl/least_loaded_part_assigner.sv
tb/testbench.sv
